// ----- design/wfpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_pkg
// Shared constants, codes and controller/datapath link types of the
// worst-fit page allocator.
// ----------------------------------------------------------------------------
package wfpa_pkg;

    localparam int HEAP_PAGES = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PG_W       = $clog2(HEAP_PAGES);       // page / entry index
    localparam int CNT_W      = PG_W + 1;                  // holds HEAP_PAGES + 1
    localparam int PFN_W      = ADDR_W - PAGE_SHIFT;       // page frame number
    localparam int NEED_W     = ADDR_W + 1 - PAGE_SHIFT;   // rounded page count
    localparam logic [31:0] HEAP_BASE_RST = 32'hF600_0000;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_MARK,
        S_RECORD,
        S_LOOKUP,
        S_CLEAR,
        S_SHIFT,
        S_RESP
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_SCAN,
        DP_PICK,
        DP_MARK,
        DP_RECORD,
        DP_LOOKUP,
        DP_CLEAR,
        DP_SHIFT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_bad;
        logic init_last;
        logic scan_done;
        logic best_found;
        logic mark_last;
        logic hit;
        logic miss;
        logic clear_last;
        logic shift_done;
    } t_dp_sts;

endpackage

// ----- design/wfpa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_dp
// Datapath: page bitmap, block table, run tracking and address arithmetic.
// ----------------------------------------------------------------------------
module wfpa_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wfpa_pkg::t_dp_cmd         i_cmd,
    output wfpa_pkg::t_dp_sts         o_sts,
    input  logic                      i_heap_base_we,
    input  logic [31:0]               i_heap_base,
    input  logic [31:0]               i_request_bytes,
    input  logic [31:0]               i_free_address,
    output logic [31:0]               o_block_address
);

    localparam int PG_W   = wfpa_pkg::PG_W;
    localparam int CNT_W  = wfpa_pkg::CNT_W;
    localparam int PFN_W  = wfpa_pkg::PFN_W;
    localparam int NEED_W = wfpa_pkg::NEED_W;
    localparam int PSH    = wfpa_pkg::PAGE_SHIFT;
    localparam logic [CNT_W-1:0] HEAP_C = CNT_W'(wfpa_pkg::HEAP_PAGES);

    logic                 r_page_used [wfpa_pkg::HEAP_PAGES];
    logic [PG_W-1:0]      r_ent_start [wfpa_pkg::HEAP_PAGES];
    logic [CNT_W-1:0]     r_ent_count [wfpa_pkg::HEAP_PAGES];

    logic [31:0]          r_base;
    logic [CNT_W-1:0]     r_cnt, r_live, r_pp, r_need;
    logic                 r_pv;
    logic                 r_tgt_ok;
    logic [PG_W-1:0]      r_tgt_page;
    logic [CNT_W-1:0]     r_run_len, r_best_len, r_cn;
    logic [PG_W-1:0]      r_run_start, r_best_start, r_idx, r_cs;
    logic [31:0]          r_res_addr, r_out_addr;
    logic                 r_pu_q;
    logic [PG_W-1:0]      r_st_q;
    logic [CNT_W-1:0]     r_cn_q;

    logic [32:0]          need_sum;
    logic [NEED_W-1:0]    need_full;
    logic [PFN_W-1:0]     tgt;
    logic                 tgt_ok;
    logic                 freep;
    logic [CNT_W-1:0]     clr_page;
    logic                 pu_we, pu_wd;
    logic [PG_W-1:0]      pu_wa;
    logic                 ent_we;
    logic [PG_W-1:0]      ent_wa, ent_ws;
    logic [CNT_W-1:0]     ent_wc;
    logic [PFN_W-1:0]     res_pfn;

    assign need_sum  = {1'b0, i_request_bytes} + 33'(wfpa_pkg::PAGE_BYTES - 1);
    assign need_full = need_sum[32:PSH];
    assign tgt       = i_free_address[31:PSH] - r_base[31:PSH];
    assign tgt_ok    = (i_free_address[PSH-1:0] == '0)
                    && (tgt < PFN_W'(wfpa_pkg::HEAP_PAGES));
    assign freep     = r_pv && (r_pp != HEAP_C) && !r_pu_q;
    assign clr_page  = {1'b0, r_cs} + r_cnt;
    assign res_pfn   = r_base[31:PSH] + PFN_W'(r_best_start);

    always_comb begin
        o_sts            = '0;
        o_sts.need_bad   = (need_full == '0) || (need_full > NEED_W'(wfpa_pkg::HEAP_PAGES));
        o_sts.init_last  = (r_cnt == HEAP_C - CNT_W'(1));
        o_sts.scan_done  = r_pv && (r_pp == HEAP_C);
        o_sts.best_found = (r_best_len != '0);
        o_sts.mark_last  = (r_cnt == r_need - CNT_W'(1));
        o_sts.hit        = r_pv && r_tgt_ok && (r_st_q == r_tgt_page);
        o_sts.miss       = !r_pv && (r_cnt >= r_live);
        o_sts.clear_last = (r_cnt == r_cn - CNT_W'(1));
        o_sts.shift_done = !r_pv && (r_cnt >= r_live);
    end

    // memory write selection
    always_comb begin
        pu_we  = 1'b0;
        pu_wa  = r_cnt[PG_W-1:0];
        pu_wd  = 1'b0;
        ent_we = 1'b0;
        ent_wa = r_live[PG_W-1:0];
        ent_ws = r_best_start;
        ent_wc = r_need;
        case (i_cmd.op)
            wfpa_pkg::DP_INIT: begin
                pu_we = 1'b1;
            end
            wfpa_pkg::DP_MARK: begin
                pu_we = 1'b1;
                pu_wa = r_best_start + r_cnt[PG_W-1:0];
                pu_wd = 1'b1;
            end
            wfpa_pkg::DP_CLEAR: begin
                pu_we = (clr_page < HEAP_C);
                pu_wa = clr_page[PG_W-1:0];
            end
            wfpa_pkg::DP_RECORD: begin
                ent_we = 1'b1;
            end
            wfpa_pkg::DP_SHIFT: begin
                ent_we = r_pv;
                ent_wa = r_pp[PG_W-1:0] - PG_W'(1);
                ent_ws = r_st_q;
                ent_wc = r_cn_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pu_we) begin
            r_page_used[pu_wa] <= pu_wd;
        end
        r_pu_q <= r_page_used[r_cnt[PG_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_start[ent_wa] <= ent_ws;
            r_ent_count[ent_wa] <= ent_wc;
        end
        r_st_q <= r_ent_start[r_cnt[PG_W-1:0]];
        r_cn_q <= r_ent_count[r_cnt[PG_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= wfpa_pkg::HEAP_BASE_RST;
        end else if (i_heap_base_we) begin
            r_base <= i_heap_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_live <= '0;
            r_pv   <= 1'b0;
        end else begin
            case (i_cmd.op)
                wfpa_pkg::DP_INIT: begin
                    r_cnt <= o_sts.init_last ? '0 : r_cnt + CNT_W'(1);
                end
                wfpa_pkg::DP_LOAD: begin
                    r_cnt       <= '0;
                    r_pv        <= 1'b0;
                    r_run_len   <= '0;
                    r_best_len  <= '0;
                    r_need      <= need_full[CNT_W-1:0];
                    r_tgt_ok    <= tgt_ok;
                    r_tgt_page  <= tgt[PG_W-1:0];
                    r_res_addr  <= '0;
                end
                wfpa_pkg::DP_SCAN: begin
                    r_pv <= (r_cnt <= HEAP_C);
                    r_pp <= r_cnt;
                    if (r_cnt <= HEAP_C) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (freep) begin
                        if (r_run_len == '0) begin
                            r_run_start <= r_pp[PG_W-1:0];
                        end
                        r_run_len <= r_run_len + CNT_W'(1);
                    end else if (r_pv && (r_run_len != '0)) begin
                        if ((r_run_len >= r_need) && (r_run_len > r_best_len)) begin
                            r_best_len   <= r_run_len;
                            r_best_start <= r_run_start;
                        end
                        r_run_len <= '0;
                    end
                end
                wfpa_pkg::DP_PICK: begin
                    r_cnt <= '0;
                end
                wfpa_pkg::DP_MARK: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                wfpa_pkg::DP_RECORD: begin
                    r_live     <= r_live + CNT_W'(1);
                    r_res_addr <= {res_pfn, PSH'(0)};
                end
                wfpa_pkg::DP_LOOKUP: begin
                    r_pv <= (r_cnt < r_live);
                    r_pp <= r_cnt;
                    if (r_cnt < r_live) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (o_sts.hit) begin
                        r_idx <= r_pp[PG_W-1:0];
                        r_cs  <= r_st_q;
                        r_cn  <= r_cn_q;
                        r_cnt <= '0;
                        r_pv  <= 1'b0;
                    end
                end
                wfpa_pkg::DP_CLEAR: begin
                    if (o_sts.clear_last) begin
                        r_cnt <= {1'b0, r_idx} + CNT_W'(1);
                        r_pv  <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                wfpa_pkg::DP_SHIFT: begin
                    r_pv <= (r_cnt < r_live);
                    r_pp <= r_cnt;
                    if (r_cnt < r_live) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (o_sts.shift_done) begin
                        r_live <= r_live - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_addr <= r_res_addr;
        end
    end

    assign o_block_address = r_out_addr;

endmodule

// ----- design/wfpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_ctrl
// Controller: request sequencing, datapath commands and output handshake.
// ----------------------------------------------------------------------------
module wfpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output wfpa_pkg::t_dp_cmd o_cmd,
    input  wfpa_pkg::t_dp_sts i_sts
);

    wfpa_pkg::t_state  r_state, n_state;
    wfpa_pkg::t_status r_code, n_code;
    wfpa_pkg::t_status r_out_status;
    logic              r_out_valid;
    logic              accept;
    logic              out_free;

    assign accept   = i_valid && (r_state == wfpa_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            wfpa_pkg::S_INIT: begin
                if (i_sts.init_last) begin
                    n_state = wfpa_pkg::S_IDLE;
                end
            end
            wfpa_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req_type == wfpa_pkg::REQ_FREE) begin
                        n_state = wfpa_pkg::S_LOOKUP;
                    end else if (i_sts.need_bad) begin
                        n_code  = wfpa_pkg::ST_NOSPACE;
                        n_state = wfpa_pkg::S_RESP;
                    end else begin
                        n_state = wfpa_pkg::S_SCAN;
                    end
                end
            end
            wfpa_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = wfpa_pkg::S_PICK;
                end
            end
            wfpa_pkg::S_PICK: begin
                if (i_sts.best_found) begin
                    n_state = wfpa_pkg::S_MARK;
                end else begin
                    n_code  = wfpa_pkg::ST_NOSPACE;
                    n_state = wfpa_pkg::S_RESP;
                end
            end
            wfpa_pkg::S_MARK: begin
                if (i_sts.mark_last) begin
                    n_state = wfpa_pkg::S_RECORD;
                end
            end
            wfpa_pkg::S_RECORD: begin
                n_code  = wfpa_pkg::ST_DONE;
                n_state = wfpa_pkg::S_RESP;
            end
            wfpa_pkg::S_LOOKUP: begin
                if (i_sts.hit) begin
                    n_state = wfpa_pkg::S_CLEAR;
                end else if (i_sts.miss) begin
                    n_code  = wfpa_pkg::ST_NOTFOUND;
                    n_state = wfpa_pkg::S_RESP;
                end
            end
            wfpa_pkg::S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = wfpa_pkg::S_SHIFT;
                end
            end
            wfpa_pkg::S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_code  = wfpa_pkg::ST_DONE;
                    n_state = wfpa_pkg::S_RESP;
                end
            end
            wfpa_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = wfpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wfpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = wfpa_pkg::DP_NOP;
        o_cmd.out_load = 1'b0;
        case (r_state)
            wfpa_pkg::S_INIT:   o_cmd.op = wfpa_pkg::DP_INIT;
            wfpa_pkg::S_IDLE:   o_cmd.op = accept ? wfpa_pkg::DP_LOAD : wfpa_pkg::DP_NOP;
            wfpa_pkg::S_SCAN:   o_cmd.op = wfpa_pkg::DP_SCAN;
            wfpa_pkg::S_PICK:   o_cmd.op = wfpa_pkg::DP_PICK;
            wfpa_pkg::S_MARK:   o_cmd.op = wfpa_pkg::DP_MARK;
            wfpa_pkg::S_RECORD: o_cmd.op = wfpa_pkg::DP_RECORD;
            wfpa_pkg::S_LOOKUP: o_cmd.op = wfpa_pkg::DP_LOOKUP;
            wfpa_pkg::S_CLEAR:  o_cmd.op = wfpa_pkg::DP_CLEAR;
            wfpa_pkg::S_SHIFT:  o_cmd.op = wfpa_pkg::DP_SHIFT;
            wfpa_pkg::S_RESP:   o_cmd.out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfpa_pkg::S_INIT;
            r_code      <= wfpa_pkg::ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.out_load) begin
            r_out_status <= r_code;
        end
    end

    assign o_stall  = (r_state != wfpa_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;

endmodule

// ----- design/worst_fit_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_page_allocator_unit
// Page-granular heap allocator with worst-fit placement and a compacted
// table of live blocks.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the page bitmap clear, one page per cycle
// with o_stall high, then takes one request at a time. An allocate
// scans every page bit through a single-port bitmap read, then marks
// one page per cycle for the pages of the block and records the entry.
// A zero or oversize request answers with no-space status and no scan.
// A free reads the block table one entry per cycle until the address
// matches, clears the block's pages one per cycle, then moves each
// later entry down one slot per cycle. The result sits in an output
// register, so a finished item waits there while the next item is
// already taken. Write heap_base only while the unit is idle.
// ----------------------------------------------------------------------------
module worst_fit_page_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_heap_base_we,
    input  logic [31:0] i_heap_base,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_free_address,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_block_address,
    output logic [1:0]  o_status
);

    wfpa_pkg::t_dp_cmd cmd;
    wfpa_pkg::t_dp_sts sts;

    // sequence requests and own the handshakes
    wfpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // hold bitmap, block table and address math
    wfpa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_heap_base_we  (i_heap_base_we),
        .i_heap_base     (i_heap_base),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .o_block_address (o_block_address)
    );

`ifndef SYNTHESIS
    // a failed request never reports an address
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != wfpa_pkg::ST_DONE)) |-> (o_block_address == 32'd0))
        else $error("failed request carries a nonzero address");

    // one item at a time: stall right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second item taken while busy");

    // reset starts the bitmap sweep
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request side open during bitmap sweep");
`endif

endmodule
